### rtl/core/rpd_pkg.sv
// shared types and constants of the row pattern dedup block
package rpd_pkg;

    localparam int MAX_STRIPES_DEF      = 4;
    localparam int PATTERN_CAPACITY_DEF = 1024;
    localparam int HASH_SLOTS_DEF       = 2048;

    localparam int KMER_W   = 64;
    localparam int WORD_W   = 64;
    localparam int ID_W     = 10;
    localparam int STATUS_W = 2;
    localparam int NS_W     = 3;

    localparam logic [63:0] MIX_CONST = 64'h9e3779b97f4a7c15;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // byte address of the stripe count register
    localparam logic [1:0] ADDR_STRIPE_COUNT = 2'd0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_WAIT,
        S_PROBE_CHK,
        S_CMP_RD,
        S_CMP_WAIT,
        S_CMP_CHK,
        S_STORE,
        S_OUT
    } state_t;

endpackage

### rtl/core/rpd_in_if.sv
// input and result channel interfaces of the row pattern dedup block
interface rpd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] seq_code;
    logic [63:0] stripe_word;
    modport source (output valid, output seq_code, output stripe_word, input ready);
    modport sink (input valid, input seq_code, input stripe_word, output ready);
endinterface

interface rpd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] row_code;
    logic [9:0]  pat_id;
    logic        is_new;
    logic [1:0]  status;
    modport source (output valid, output row_code, output pat_id, output is_new,
                    output status, input ready);
    modport sink (input valid, input row_code, input pat_id, input is_new,
                  input status, output ready);
endinterface

### rtl/core/rpd_ram.sv
// generic single port ram with registered read
module rpd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write, and registered read of the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/core/row_pattern_dedup_id_assign_top.sv
// top level of the row pattern dedup and id assignment block
// a stripe item that does not complete a row is only stored; a completing item
// then takes n hash steps, PROBE_RD, PROBE_WAIT and PROBE_CHK per probed slot,
// CMP_RD, CMP_WAIT and CMP_CHK per compared stripe word, MAX_STRIPES word
// stores for a new pattern, then S_OUT until taken; a code mismatch row goes
// straight to output; throughput is one item at a time, set by the shared
// slot and store ram ports; reset: a clearing pass walks the slot valid ram
// after reset and every stripe count write; no item is taken meanwhile
module row_pattern_dedup_id_assign_top #(
    parameter int MAX_STRIPES      = rpd_pkg::MAX_STRIPES_DEF,
    parameter int PATTERN_CAPACITY = rpd_pkg::PATTERN_CAPACITY_DEF,
    parameter int HASH_SLOTS       = rpd_pkg::HASH_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rpd_in_if.sink       in_ch,
    rpd_out_if.source    out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rpd_pkg::*;

    localparam int SLOT_AW = $clog2(HASH_SLOTS);
    localparam int PID_W   = $clog2(PATTERN_CAPACITY);
    localparam int STR_W   = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
    localparam int STORE_D = PATTERN_CAPACITY * MAX_STRIPES;
    localparam int STORE_AW = $clog2(STORE_D);
    localparam int POS_W   = $clog2(MAX_STRIPES + 1);
    localparam int CNT_W   = $clog2(PATTERN_CAPACITY + 1);
    localparam int SLOT_DW = PID_W + 1;

    state_t state_reg, state_next;

    logic [NS_W-1:0]   stripe_count_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [63:0]       first_code_reg, first_code_next;
    logic              mism_reg, mism_next;
    logic [WORD_W-1:0] row_words_reg [MAX_STRIPES];
    logic [63:0]       hash_reg, hash_next;
    logic [POS_W-1:0]  step_reg, step_next;
    logic [SLOT_AW-1:0] slot_reg, slot_next;
    logic [SLOT_AW:0]  probes_reg, probes_next;
    logic [PID_W-1:0]  cand_reg, cand_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ID_W-1:0]   pid_reg, pid_next;
    logic              new_reg, new_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_AW:0]  clr_reg, clr_next;

    logic [POS_W-1:0]  row_len;
    logic              cfg_wr;
    logic              in_fire;
    logic [POS_W-1:0]  wpos;
    logic              word_we;

    // slot ram: valid bit and pattern id
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_addr;
    logic [SLOT_DW-1:0] slot_wdata, slot_rdata;

    // pattern store ram
    logic                store_we;
    logic [STORE_AW-1:0] store_addr;
    logic [WORD_W-1:0]   store_wdata, store_rdata;

    rpd_ram #(.WIDTH(SLOT_DW), .DEPTH(HASH_SLOTS)) u_slot_ram (
        .clk(clk), .we(slot_we), .addr(slot_addr), .wdata(slot_wdata), .rdata(slot_rdata)
    );

    rpd_ram #(.WIDTH(WORD_W), .DEPTH(STORE_D)) u_store_ram (
        .clk(clk), .we(store_we), .addr(store_addr), .wdata(store_wdata),
        .rdata(store_rdata)
    );

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_STRIPE_COUNT);
    assign prdata = (paddr == ADDR_STRIPE_COUNT) ?
                    {{(32-NS_W){1'b0}}, stripe_count_reg} : 32'd0;

    // effective row length
    always_comb
    begin
        if (stripe_count_reg == '0)
        begin
            row_len = POS_W'(1);
        end
        else if (32'(stripe_count_reg) > MAX_STRIPES)
        begin
            row_len = POS_W'(MAX_STRIPES);
        end
        else
        begin
            row_len = POS_W'(stripe_count_reg);
        end
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign wpos        = (pos_reg >= row_len) ? '0 : pos_reg;

    assign out_ch.valid    = (state_reg == S_OUT);
    assign out_ch.row_code = first_code_reg;
    assign out_ch.pat_id   = pid_reg;
    assign out_ch.is_new   = new_reg;
    assign out_ch.status   = status_reg;

    // control and datapath
    always_comb
    begin
        logic [63:0] w;
        state_next      = state_reg;
        pos_next        = pos_reg;
        first_code_next = first_code_reg;
        mism_next       = mism_reg;
        hash_next       = hash_reg;
        step_next       = step_reg;
        slot_next       = slot_reg;
        probes_next     = probes_reg;
        cand_next       = cand_reg;
        count_next      = count_reg;
        pid_next        = pid_reg;
        new_next        = new_reg;
        status_next     = status_reg;
        clr_next        = clr_reg;
        word_we         = 1'b0;
        slot_we         = 1'b0;
        slot_addr       = slot_reg;
        slot_wdata      = '0;
        store_we        = 1'b0;
        store_addr      = STORE_AW'(32'(cand_reg) * MAX_STRIPES + 32'(step_reg));
        store_wdata     = '0;
        w               = row_words_reg[step_reg[STR_W-1:0]];

        case (state_reg)
            S_CLEAR:
            begin
                slot_we   = 1'b1;
                slot_addr = clr_reg[SLOT_AW-1:0];
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == HASH_SLOTS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    word_we = 1'b1;
                    if (wpos == '0)
                    begin
                        first_code_next = in_ch.seq_code;
                        mism_next       = 1'b0;
                    end
                    else if (in_ch.seq_code != first_code_reg)
                    begin
                        mism_next = 1'b1;
                    end
                    if (wpos + 1'b1 < row_len)
                    begin
                        pos_next = wpos + 1'b1;
                    end
                    else
                    begin
                        pos_next = '0;
                        new_next = 1'b0;
                        pid_next = '0;
                        if (mism_next)
                        begin
                            status_next = ST_MISMATCH;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            hash_next  = 64'(row_len);
                            step_next  = '0;
                            state_next = S_HASH;
                        end
                    end
                end
            end
            S_HASH:
            begin
                // one mixing step per cycle
                hash_next = hash_reg ^ (w + MIX_CONST + (hash_reg << 6) + (hash_reg >> 2));
                step_next = step_reg + 1'b1;
                if (step_reg + 1'b1 == row_len)
                begin
                    slot_next   = hash_next[SLOT_AW-1:0];
                    probes_next = '0;
                    state_next  = S_PROBE_RD;
                end
            end
            S_PROBE_RD:
            begin
                if (32'(probes_reg) == HASH_SLOTS)
                begin
                    status_next = ST_FULL;
                    pid_next    = ID_W'(PATTERN_CAPACITY - 1);
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_PROBE_WAIT;
                end
            end
            S_PROBE_WAIT:
            begin
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                if (!slot_rdata[SLOT_DW-1])
                begin
                    if (32'(count_reg) < PATTERN_CAPACITY)
                    begin
                        cand_next  = count_reg[PID_W-1:0];
                        step_next  = '0;
                        state_next = S_STORE;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                        pid_next    = ID_W'(PATTERN_CAPACITY - 1);
                        state_next  = S_OUT;
                    end
                end
                else
                begin
                    cand_next  = slot_rdata[PID_W-1:0];
                    step_next  = '0;
                    state_next = S_CMP_RD;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_WAIT;
            end
            S_CMP_WAIT:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (store_rdata != w)
                begin
                    slot_next   = slot_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    state_next  = S_PROBE_RD;
                end
                else if (step_reg + 1'b1 == row_len)
                begin
                    pid_next    = ID_W'(cand_reg);
                    status_next = ST_OK;
                    state_next  = S_OUT;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_STORE:
            begin
                // one stripe word per cycle, claiming the slot with the last word
                store_we    = 1'b1;
                store_wdata = (step_reg < row_len) ? w : '0;
                step_next   = step_reg + 1'b1;
                if (32'(step_reg) == MAX_STRIPES - 1)
                begin
                    slot_we     = 1'b1;
                    slot_wdata  = {1'b1, cand_reg};
                    pid_next    = ID_W'(cand_reg);
                    count_next  = count_reg + 1'b1;
                    new_next    = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write restarts the dictionary
        if (cfg_wr)
        begin
            pos_next   = '0;
            mism_next  = 1'b0;
            count_next = '0;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            stripe_count_reg <= NS_W'(1);
            pos_reg          <= '0;
            first_code_reg   <= '0;
            mism_reg         <= 1'b0;
            count_reg        <= '0;
            clr_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            first_code_reg <= first_code_next;
            mism_reg       <= mism_next;
            count_reg      <= count_next;
            clr_reg        <= clr_next;
            if (cfg_wr)
            begin
                stripe_count_reg <= pwdata[NS_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hash_reg   <= hash_next;
        step_reg   <= step_next;
        slot_reg   <= slot_next;
        probes_reg <= probes_next;
        cand_reg   <= cand_next;
        pid_reg    <= pid_next;
        new_reg    <= new_next;
        status_reg <= status_next;
        if (word_we)
        begin
            row_words_reg[wpos[STR_W-1:0]] <= in_ch.stripe_word;
        end
    end
endmodule
